### rtl/bcc_pkg.sv
package bcc_pkg;

   localparam int NUM_COEFFS = 4;
   localparam int COEFF_COUNT = (NUM_COEFFS < 1) ? 1 : ((NUM_COEFFS > 4) ? 4 : NUM_COEFFS);
   localparam int COEFF_SLOTS = 4;
   localparam int KIDX_W = 2;
   localparam logic [KIDX_W-1:0] COEFF_TOP = KIDX_W'(COEFF_COUNT - 1);

   localparam int DATA_W = 32;
   localparam int CELLS_W = 8;
   localparam int GAIN_W = 31;
   localparam int IDOD_W = 23;
   localparam int PROD_W = 64;
   localparam int RND_W = 48;
   localparam int STEP_W = 3;
   localparam int ADDR_W = 5;
   localparam int FRAC_W = 16;

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd32768);

   typedef enum logic [2:0] {
      REG_COEFF_ZERO,
      REG_COEFF_ONE,
      REG_COEFF_TWO,
      REG_COEFF_THREE,
      REG_SERIES_CELLS,
      REG_DOD_GAIN,
      REG_CAPACITY_PER_PERCENT,
      REG_DOD_PRESET
   } reg_index_type;

   typedef enum logic [1:0] {
      SRC_A_CURRENT,
      SRC_A_DOD,
      SRC_A_ACC
   } src_a_type;

   typedef enum logic [1:0] {
      SRC_B_GAIN,
      SRC_B_CAPACITY,
      SRC_B_CAP,
      SRC_B_CELLS
   } src_b_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_DOD,
      WB_CAP,
      WB_ACC,
      WB_DONE
   } wb_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_IF_LAST,
      JMP_ALWAYS
   } jump_type;

   typedef struct packed {
      src_a_type         src_a;
      src_b_type         src_b;
      wb_type            wb;
      jump_type          jump;
      logic [STEP_W-1:0] target;
   } uop_type;

   typedef struct packed {
      src_a_type         src_a;
      src_b_type         src_b;
      wb_type            wb;
      logic [KIDX_W-1:0] coeff_idx;
      logic              fire;
   } dp_ctrl_type;

   // microcode program
   function automatic uop_type ucode(input logic [STEP_W-1:0] step);
      uop_type u;
      u = '{SRC_A_CURRENT, SRC_B_GAIN, WB_NONE, JMP_NEXT, STEP_W'(0)};
      case (step)
         3'd0: u = '{SRC_A_CURRENT, SRC_B_GAIN, WB_NONE, JMP_NEXT, STEP_W'(0)};
         3'd1: u = '{SRC_A_CURRENT, SRC_B_GAIN, WB_DOD, JMP_NEXT, STEP_W'(0)};
         3'd2: u = '{SRC_A_DOD, SRC_B_CAPACITY, WB_NONE, JMP_NEXT, STEP_W'(0)};
         3'd3: u = '{SRC_A_DOD, SRC_B_CAPACITY, WB_CAP, JMP_NEXT, STEP_W'(0)};
         3'd4: u = '{SRC_A_ACC, SRC_B_CAP, WB_NONE, JMP_IF_LAST, STEP_W'(6)};
         3'd5: u = '{SRC_A_ACC, SRC_B_CAP, WB_ACC, JMP_ALWAYS, STEP_W'(4)};
         3'd6: u = '{SRC_A_ACC, SRC_B_CELLS, WB_NONE, JMP_NEXT, STEP_W'(0)};
         3'd7: u = '{SRC_A_ACC, SRC_B_CELLS, WB_DONE, JMP_NEXT, STEP_W'(0)};
         default: u = '{SRC_A_CURRENT, SRC_B_GAIN, WB_NONE, JMP_NEXT, STEP_W'(0)};
      endcase
      return u;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > PROD_W'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < PROD_W'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/bcc_seq.sv
module bcc_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 out_stall,
   output logic                 busy,
   output logic                 done,
   output bcc_pkg::dp_ctrl_type ctrl
);
   import bcc_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [KIDX_W-1:0] k_ff, k_in;
   uop_type           uop;
   logic              fire;

   assign uop = ucode(step_ff);
   assign fire = busy_ff && !((uop.wb == WB_DONE) && out_stall);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      k_in = k_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = '0;
         end
      end else if (fire) begin
         if (uop.wb == WB_DONE) begin
            busy_in = 1'b0;
         end
         case (uop.jump)
            JMP_IF_LAST: step_in = (k_ff == '0) ? uop.target : step_ff + 1'b1;
            JMP_ALWAYS:  step_in = uop.target;
            default:     step_in = step_ff + 1'b1;
         endcase
         case (uop.wb)
            WB_CAP:  k_in = COEFF_TOP;
            WB_ACC:  k_in = k_ff - 1'b1;
            default: k_in = k_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         k_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         k_ff <= k_in;
      end
   end

   assign busy = busy_ff;
   assign done = fire && (uop.wb == WB_DONE);
   assign ctrl.src_a = uop.src_a;
   assign ctrl.src_b = uop.src_b;
   assign ctrl.wb = uop.wb;
   assign ctrl.coeff_idx = (uop.wb == WB_CAP) ? COEFF_TOP : k_ff - 1'b1;
   assign ctrl.fire = fire;

endmodule

### rtl/bcc_dp.sv
module bcc_dp (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  bcc_pkg::dp_ctrl_type                                   ctrl,
   input  logic                                                   load_current,
   input  logic signed [bcc_pkg::DATA_W-1:0]                      current,
   input  logic                                                   load_dod,
   input  logic [bcc_pkg::IDOD_W-1:0]                             dod_preset,
   input  logic [bcc_pkg::COEFF_SLOTS-1:0][bcc_pkg::DATA_W-1:0]   coeff,
   input  logic [bcc_pkg::CELLS_W-1:0]                            series_cells,
   input  logic [bcc_pkg::GAIN_W-1:0]                             dod_gain,
   input  logic [bcc_pkg::GAIN_W-1:0]                             capacity_per_percent,
   output logic signed [bcc_pkg::DATA_W-1:0]                      pack_voltage,
   output logic signed [bcc_pkg::DATA_W-1:0]                      depth_of_discharge
);
   import bcc_pkg::*;

   logic signed [DATA_W-1:0] cur_ff, cur_in;
   logic signed [DATA_W-1:0] dod_ff, dod_in;
   logic signed [DATA_W-1:0] cap_ff, cap_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic signed [DATA_W-1:0] op_a, op_b, coef_sel, rnd_sat;
   logic signed [PROD_W-1:0] rounded, rnd_ext, dod_diff, acc_sum;
   logic signed [RND_W-1:0]  rnd;

   always_comb begin
      case (ctrl.src_a)
         SRC_A_DOD: op_a = dod_ff;
         SRC_A_ACC: op_a = acc_ff;
         default:   op_a = cur_ff;
      endcase
      case (ctrl.src_b)
         SRC_B_GAIN:     op_b = {1'b0, dod_gain};
         SRC_B_CAPACITY: op_b = {1'b0, capacity_per_percent};
         SRC_B_CAP:      op_b = cap_ff;
         default:        op_b = {{(DATA_W-CELLS_W){1'b0}}, series_cells};
      endcase
   end

   assign prod_in = ctrl.fire ? PROD_W'(op_a) * PROD_W'(op_b) : prod_ff;

   // round half up and drop the fraction
   assign rounded = prod_ff + ROUND_HALF;
   assign rnd = rounded[RND_W+FRAC_W-1:FRAC_W];
   assign rnd_ext = PROD_W'(rnd);
   assign rnd_sat = sat32(rnd_ext);
   assign coef_sel = coeff[ctrl.coeff_idx];
   assign dod_diff = PROD_W'(dod_ff) - rnd_ext;
   assign acc_sum = PROD_W'(rnd_sat) + PROD_W'(coef_sel);

   always_comb begin
      cur_in = load_current ? current : cur_ff;
      dod_in = dod_ff;
      cap_in = cap_ff;
      acc_in = acc_ff;
      if (load_dod) begin
         dod_in = {{(DATA_W-IDOD_W){1'b0}}, dod_preset};
      end else if (ctrl.fire) begin
         case (ctrl.wb)
            WB_DOD: dod_in = sat32(dod_diff);
            WB_CAP: begin
               cap_in = rnd_sat;
               acc_in = coef_sel;
            end
            WB_ACC:  acc_in = sat32(acc_sum);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dod_ff <= '0;
      end else begin
         dod_ff <= dod_in;
      end
      cur_ff <= cur_in;
      cap_ff <= cap_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
   end

   assign pack_voltage = sat32(prod_ff);
   assign depth_of_discharge = dod_ff;

endmodule

### rtl/battery_coulomb_counter_poly_voltage.sv
// battery fuel gauge by coulomb counting with a polynomial cell voltage curve
// req channel: one transaction per tick carrying the signed Q16.16 charge current
// rsp channel: one transaction per tick with pack voltage and depth of discharge
// csr port: apb-style writes of the polynomial coefficients, series cell count,
//   discharge gain, capacity per percent and preset depth of discharge;
//   writing the preset also reloads the depth of discharge at once
// a microcoded sequencer steps one shared 32x32 multiplier through the update:
//   discharge delta, capacity, a horner step per coefficient but the top, cell scaling
// the latency is set by the dependent multiplies and the number of coefficients
// one tick at a time: req_tready is high only while the sequencer is idle,
//   so a new req is accepted only after the previous one has finished
// the finished result sits in an output register; if it is still full and
//   rsp_tready is low, the sequencer parks on its last step until it is free
// reset clears the coefficients, gain and capacity, sets series cells to one
//   and loads a depth of discharge of zero
module battery_coulomb_counter_poly_voltage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,    // charge_current
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,    // depth_of_discharge, pack_voltage
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bcc_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import bcc_pkg::*;

   logic [COEFF_SLOTS-1:0][DATA_W-1:0] coeff_ff, coeff_in;
   logic [CELLS_W-1:0] cells_ff, cells_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [GAIN_W-1:0]  capp_ff, capp_in;
   logic [IDOD_W-1:0]  idod_ff, idod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;

   logic               wr_en, load_dod, busy, done, accept;
   reg_index_type      wr_idx, rd_idx;
   dp_ctrl_type        ctrl;
   logic signed [DATA_W-1:0] pack_voltage, depth_of_discharge;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_idx = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign rd_idx = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign load_dod = wr_en && (wr_idx == REG_DOD_PRESET);

   always_comb begin
      coeff_in = coeff_ff;
      cells_in = cells_ff;
      gain_in = gain_ff;
      capp_in = capp_ff;
      idod_in = idod_ff;
      if (wr_en) begin
         case (wr_idx)
            REG_COEFF_ZERO:           coeff_in[0] = csr_pwdata;
            REG_COEFF_ONE:            coeff_in[1] = csr_pwdata;
            REG_COEFF_TWO:            coeff_in[2] = csr_pwdata;
            REG_COEFF_THREE:          coeff_in[3] = csr_pwdata;
            REG_SERIES_CELLS:         cells_in = csr_pwdata[CELLS_W-1:0];
            REG_DOD_GAIN:             gain_in = csr_pwdata[GAIN_W-1:0];
            REG_CAPACITY_PER_PERCENT: capp_in = csr_pwdata[GAIN_W-1:0];
            REG_DOD_PRESET:           idod_in = csr_pwdata[IDOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (rd_idx)
         REG_COEFF_ZERO:           csr_prdata = coeff_ff[0];
         REG_COEFF_ONE:            csr_prdata = coeff_ff[1];
         REG_COEFF_TWO:            csr_prdata = coeff_ff[2];
         REG_COEFF_THREE:          csr_prdata = coeff_ff[3];
         REG_SERIES_CELLS:         csr_prdata = {{(32-CELLS_W){1'b0}}, cells_ff};
         REG_DOD_GAIN:             csr_prdata = {{(32-GAIN_W){1'b0}}, gain_ff};
         REG_CAPACITY_PER_PERCENT: csr_prdata = {{(32-GAIN_W){1'b0}}, capp_ff};
         REG_DOD_PRESET:           csr_prdata = {{(32-IDOD_W){1'b0}}, idod_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   assign req_tready = !busy;
   assign accept = req_tvalid && req_tready;

   bcc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .out_stall (rsp_valid_ff && !rsp_tready),
      .busy      (busy),
      .done      (done),
      .ctrl      (ctrl)
   );

   bcc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .ctrl                 (ctrl),
      .load_current         (accept),
      .current              (req_tdata),
      .load_dod             (load_dod),
      .dod_preset           (csr_pwdata[IDOD_W-1:0]),
      .coeff                (coeff_ff),
      .series_cells         (cells_ff),
      .dod_gain             (gain_ff),
      .capacity_per_percent (capp_ff),
      .pack_voltage         (pack_voltage),
      .depth_of_discharge   (depth_of_discharge)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {depth_of_discharge, pack_voltage};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
         cells_ff <= CELLS_W'(1);
         gain_ff <= '0;
         capp_ff <= '0;
         idod_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coeff_ff <= coeff_in;
         cells_ff <= cells_in;
         gain_ff <= gain_in;
         capp_ff <= capp_in;
         idod_ff <= idod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
